// File: rtl/core/spi_clock_divisor_search_assert.svh
// Assertion macros shared by the clock divisor search modules.
`ifndef SPI_CLOCK_DIVISOR_SEARCH_ASSERT_SVH
`define SPI_CLOCK_DIVISOR_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SCDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scds assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SCDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scds assertion failed");

`endif

// File: rtl/core/scds_pkg.sv
// Types and constants of the serial clock divisor search.
`default_nettype none

package scds_pkg;

	localparam logic [7:0]  PRE_MIN   = 8'd2;
	localparam logic [7:0]  PRE_MAX   = 8'd254;
	localparam logic [8:0]  POST_MAX  = 9'd256;
	localparam logic [8:0]  POST_LAST = 9'd2;
	localparam logic [31:0] SRC_RESET = 32'd125000000;
	localparam logic [4:0]  DIV_LAST  = 5'd31;
	localparam logic [1:0]  ADDR_SRC  = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_KMUL,
		ST_PINIT,
		ST_POST,
		ST_DINIT,
		ST_DIV,
		ST_FIN
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic pre_step;
		logic k_mul;
		logic post_init;
		logic post_step;
		logic div_init;
		logic div_step;
		logic out_load;
		logic out_ok;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic bad_req;
		logic pre_hit;
		logic pre_last;
		logic post_hit;
		logic post_last;
		logic div_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/scds_ctrl.sv
// Sequencer of the divisor search: prescale scan, post scan, divide, output.
`default_nettype none

module scds_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output scds_pkg::dp_cmd_t      cmd,
	input  wire scds_pkg::dp_stat_t stat
);
	import scds_pkg::*;

	state_t state_q, state_d;
	logic   ok_q, ok_d;
	logic   out_valid_q;

	// State, result flag and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		ok_d     = ok_q;
		cmd      = '0;
		cmd.out_ok = ok_q;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.bad_req) begin
						ok_d    = 1'b0;
						state_d = ST_FIN;
					end else begin
						state_d = ST_PRE;
					end
				end
			end
			ST_PRE: begin
				if (stat.pre_hit) begin
					state_d = ST_KMUL;
				end else if (stat.pre_last) begin
					ok_d    = 1'b0;
					state_d = ST_FIN;
				end else begin
					cmd.pre_step = 1'b1;
				end
			end
			ST_KMUL: begin
				cmd.k_mul = 1'b1;
				state_d   = ST_PINIT;
			end
			ST_PINIT: begin
				cmd.post_init = 1'b1;
				state_d       = ST_POST;
			end
			ST_POST: begin
				if (stat.post_hit) begin
					state_d = ST_DINIT;
				end else begin
					cmd.post_step = 1'b1;
					if (stat.post_last) begin
						state_d = ST_DINIT;
					end
				end
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					ok_d    = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!(out_valid_q && out_stall)) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`include "spi_clock_divisor_search_assert.svh"

	// A waiting result is never overwritten
	`SCDS_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && out_stall, !cmd.out_load)
	// An accepted item always starts work
	`SCDS_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, state_q != ST_IDLE)

endmodule

`default_nettype wire

// File: rtl/core/scds_dp.sv
// Datapath: prescale accumulator, post-divider scan and restoring divider.
`default_nettype none

module scds_dp (
	input  wire logic               clk,
	input  wire logic [31:0]        requested_hz,
	input  wire logic [31:0]        src,
	input  wire scds_pkg::dp_cmd_t  cmd,
	output scds_pkg::dp_stat_t      stat,
	output logic                    profile_valid,
	output logic [7:0]              prescale_value,
	output logic [8:0]              post_divider,
	output logic [31:0]             achieved_hz
);
	import scds_pkg::*;

	logic [31:0] req_q;
	logic [39:0] acc_q;     // prescale * request
	logic [7:0]  pre_q;
	logic [40:0] k_q;       // (request + 1) * prescale
	logic [48:0] prod_q;    // k * (post - 1)
	logic [8:0]  post_q;
	logic [15:0] dvs_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;

	logic [39:0] two_req;
	logic [32:0] req_inc;
	logic [40:0] k_next;
	logic [48:0] prod_init;
	logic [16:0] dvs_next;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;

	// Step arithmetic
	always_comb begin
		two_req   = {7'b0, req_q, 1'b0};
		req_inc   = {1'b0, req_q} + 33'd1;
		k_next    = {8'b0, req_inc} * {33'b0, pre_q};
		prod_init = {k_q, 8'b0} - {8'b0, k_q};
		dvs_next  = {9'b0, pre_q} * {8'b0, post_q};
		trial     = {rem_q, quo_q[31]};
		diff      = trial - {1'b0, dvs_q};
		ge        = (trial >= {1'b0, dvs_q});
	end

	// Status to the controller
	always_comb begin
		stat.bad_req   = (requested_hz == 32'd0) || (requested_hz > src);
		// src < acc * 256 is the same as src / 256 < acc
		stat.pre_hit   = ({16'b0, src[31:8]} < acc_q);
		stat.pre_last  = (pre_q == PRE_MAX);
		// src / d > req is the same as src >= (req + 1) * d
		stat.post_hit  = ({17'b0, src} >= prod_q);
		stat.post_last = (post_q == POST_LAST);
		stat.div_last  = (cnt_q == DIV_LAST);
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= requested_hz;
			pre_q <= PRE_MIN;
			acc_q <= {7'b0, requested_hz, 1'b0};
		end
		if (cmd.pre_step) begin
			pre_q <= pre_q + PRE_MIN;
			acc_q <= acc_q + two_req;
		end
		if (cmd.k_mul) begin
			k_q <= k_next;
		end
		if (cmd.post_init) begin
			prod_q <= prod_init;
			post_q <= POST_MAX;
		end
		if (cmd.post_step) begin
			prod_q <= prod_q - {8'b0, k_q};
			post_q <= post_q - 9'd1;
		end
		if (cmd.div_init) begin
			dvs_q <= dvs_next[15:0];
			rem_q <= '0;
			quo_q <= src;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], ge};
			cnt_q <= cnt_q + 5'd1;
		end
	end

	// Output item register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			profile_valid  <= cmd.out_ok;
			prescale_value <= cmd.out_ok ? pre_q : 8'd0;
			post_divider   <= cmd.out_ok ? post_q : 9'd0;
			achieved_hz    <= cmd.out_ok ? quo_q : 32'd0;
		end
	end

	`include "spi_clock_divisor_search_assert.svh"

	// Partial remainder stays below the divisor
	`SCDS_ASSERT_NOW(a_rem_range, clk, 1'b1, cmd.div_step, rem_q < dvs_q)
	// Prescale scan only advances over even values below the limit
	`SCDS_ASSERT_NOW(a_pre_range, clk, 1'b1, cmd.pre_step, !pre_q[0] && (pre_q < PRE_MAX))
	// Post scan never steps below one
	`SCDS_ASSERT_NOW(a_post_range, clk, 1'b1, cmd.post_step, post_q >= POST_LAST)

endmodule

`default_nettype wire

// File: rtl/core/spi_clock_divisor_search.sv
// Serial clock divisor search: one result item per requested rate item.
// A zero request or one above the source skips the search and gives an invalid result; so
// does a prescale scan that would pass 254. Otherwise a scan of even prescale values (2..254)
// is followed by a post scan from 256 down (ending at 1 at the latest) and the divider.
// One item at a time: requests stall until the result is loaded, which out_stall can delay.
// Reset (arst_n low, asynchronous): idle, no result pending, source = 125000000.
`default_nettype none

module spi_clock_divisor_search (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] requested_hz,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             profile_valid,
	output logic [7:0]       prescale_value,
	output logic [8:0]       post_divider,
	output logic [31:0]      achieved_hz,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import scds_pkg::*;

	logic [31:0] src_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;

	// Source clock register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SRC_RESET;
		end else if (psel && penable && pwrite && (paddr == ADDR_SRC)) begin
			src_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_SRC) ? src_q : 32'd0;

	scds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	scds_dp u_dp (
		.clk            (clk),
		.requested_hz   (requested_hz),
		.src            (src_q),
		.cmd            (cmd),
		.stat           (stat),
		.profile_valid  (profile_valid),
		.prescale_value (prescale_value),
		.post_divider   (post_divider),
		.achieved_hz    (achieved_hz)
	);

endmodule

`default_nettype wire
